// File: rtl/ahsbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ahsbf_pkg;

    localparam int PIXEL_W = 32;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 2;

    localparam logic [PIXEL_W-1:0] BYTE_LSB_CLEAR = 32'hfefe_fefe;

    localparam logic [IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    // Result waiting for the line store read data.
    typedef struct packed {
        logic [PIXEL_W-1:0] pair;
        logic               last;
        logic               err;
    } t_pend;

    // Per-byte truncated average without carries between bytes.
    function automatic logic [PIXEL_W-1:0] byte_avg(input logic [PIXEL_W-1:0] a,
                                                    input logic [PIXEL_W-1:0] b);
        byte_avg = (((a ^ b) & BYTE_LSB_CLEAR) >> 1) + (a & b);
    endfunction

endpackage

`default_nettype wire

// File: rtl/ahsbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ahsbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/argb_half_scale_box_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// The line store has one write and one read port; a result passes the pending stage, then
// the output register. Throughput: one pixel per cycle unless the output side stalls.
// Reset: synchronous, active low; width 640, height 480, positions and pipeline cleared.
// The line store is not cleared: an odd row only reads entries the even row above wrote.
// A configuration write restarts the image at column 0, row 0.
module argb_half_scale_box_filter
    import ahsbf_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input pixel stream
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [PIXEL_W-1:0] i_pixel,
    // result stream
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [PIXEL_W-1:0] o_scaled_pixel,
    output logic                    o_last_of_image,
    output logic                    o_odd_size_error,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    // Store depth and position widths all follow from the maximum sizes.
    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = ($clog2(MAX_WIDTH) > 1) ? $clog2(MAX_WIDTH) : 2;
    localparam int ROW_W  = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) : 2;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int TOP_W  = (MAX_WIDTH / 2) * 2;
    localparam int TOP_H  = (MAX_HEIGHT / 2) * 2;

    logic [CFG_W-1:0]   r_line_width, r_image_height;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [PIXEL_W-1:0] r_left;

    logic               r_pend_valid, n_pend_valid;
    t_pend              r_pend;

    logic               r_out_valid, n_out_valid;
    logic [PIXEL_W-1:0] r_out_pixel;
    logic               r_out_last, r_out_err;

    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic               odd_size, accept, pend_adv;
    logic               col_end, row_end, is_last;
    logic               store_we, store_re;
    logic [AW-1:0]      slot;
    logic [PIXEL_W-1:0] pair, stored_pair;

    // Clamp the written sizes to the even range the store supports; zero counts as two.
    always_comb begin
        if (r_line_width < CFG_W'(2)) begin
            w_eff = WW'(2);
        end else if (32'(r_line_width) > TOP_W) begin
            w_eff = WW'(TOP_W);
        end else begin
            w_eff = WW'(r_line_width);
        end
        if (r_image_height < CFG_W'(2)) begin
            h_eff = HW'(2);
        end else if (32'(r_image_height) > TOP_H) begin
            h_eff = HW'(TOP_H);
        end else begin
            h_eff = HW'(r_image_height);
        end
    end

    // The odd check looks at the raw register values, not the clamped ones.
    assign odd_size = r_line_width[0] | r_image_height[0];

    // Pending result moves to the output register when that register is free or drains.
    assign pend_adv = r_pend_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_pend_valid || pend_adv;
    assign accept   = i_valid && o_ready;

    assign col_end = (WW'(r_col) == w_eff - WW'(1));
    assign row_end = (HW'(r_row) == h_eff - HW'(1));
    assign is_last = col_end && row_end;

    assign pair = byte_avg(r_left, i_pixel);
    assign slot = AW'(r_col >> 1);

    // Even row, odd column: write the pair average. Odd row, odd column: fetch it back.
    assign store_we = accept && !odd_size && r_col[0] && !r_row[0];
    assign store_re = accept && !odd_size && r_col[0] && r_row[0];

    ahsbf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (slot),
        .i_wdata (pair),
        .i_re    (store_re),
        .i_raddr (slot),
        .o_rdata (stored_pair)
    );

    // Advance column and row; wrap at the clamped size.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept && !odd_size) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_comb begin
        n_pend_valid = r_pend_valid;
        if (pend_adv) begin
            n_pend_valid = 1'b0;
        end
        if (accept && (odd_size || store_re)) begin
            n_pend_valid = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (pend_adv) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_left         <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                // Any write, even to an unused index, restarts the image.
                case (i_cfg_index)
                    CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
            // Hold the even-column pixel for the pair average.
            if (accept && !odd_size && !r_col[0]) begin
                r_left <= i_pixel;
            end
        end
    end

    // Payload of the pending stage and the output register.
    always_ff @(posedge i_clk) begin
        if (accept && (odd_size || store_re)) begin
            r_pend.pair <= pair;
            r_pend.last <= is_last && !odd_size;
            r_pend.err  <= odd_size;
        end
        if (pend_adv) begin
            // Store read data is valid here: no new read issues while the stage waits.
            r_out_pixel <= r_pend.err ? '0 : byte_avg(stored_pair, r_pend.pair);
            r_out_last  <= r_pend.last;
            r_out_err   <= r_pend.err;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_scaled_pixel   = r_out_pixel;
    assign o_last_of_image  = r_out_last;
    assign o_odd_size_error = r_out_err;

endmodule

`default_nettype wire

// File: tb/ahsbf_result_checker.sv
`timescale 1ns / 1ps

module ahsbf_result_checker
    import ahsbf_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pix_valid,
    input  logic               i_pix_ready,
    input  logic [PIXEL_W-1:0] i_pixel,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [PIXEL_W-1:0] i_scaled_pixel,
    input  logic               i_last_of_image,
    input  logic               i_odd_size_error,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int PAIR_DEPTH = MAX_WIDTH / 2;

    typedef struct packed {
        logic [PIXEL_W-1:0] scaled;
        logic               last;
        logic               odd_err;
    } t_scaled_result;

    logic [CFG_W-1:0]   line_width;
    logic [CFG_W-1:0]   image_height;
    logic [PIXEL_W-1:0] pair_row [PAIR_DEPTH];
    logic [PIXEL_W-1:0] left_pixel;
    int                 col;
    int                 row;
    t_scaled_result     expected_results [$];
    int                 fails = 0;
    int                 checked = 0;

    // Per-byte mean, dropping the half bit.
    function automatic logic [PIXEL_W-1:0] average_bytes(input logic [PIXEL_W-1:0] a,
                                                         input logic [PIXEL_W-1:0] b);
        logic [8:0]         sum;
        logic [PIXEL_W-1:0] avg;
        for (int k = 0; k < PIXEL_W / 8; k++) begin
            sum = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
            avg[8*k +: 8] = sum[8:1];
        end
        return avg;
    endfunction

    function automatic int even_size(input logic [CFG_W-1:0] v, input int limit);
        int top;
        top = limit & ~1;
        if (top < 2) top = 2;
        if (v < 2) return 2;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    task automatic predict_pixel(input logic [PIXEL_W-1:0] px);
        int                 w;
        int                 h;
        int                 slot;
        logic [PIXEL_W-1:0] pair;
        t_scaled_result     res;
        if (line_width[0] || image_height[0]) begin
            // odd size: flag every pixel, keep position
            res.scaled  = '0;
            res.last    = 1'b0;
            res.odd_err = 1'b1;
            expected_results.push_back(res);
        end else begin
            w = even_size(line_width, MAX_WIDTH);
            h = even_size(image_height, MAX_HEIGHT);
            if (col >= w) col = 0;
            if (row >= h) row = 0;
            if (col % 2 == 0) begin
                left_pixel = px;
            end else begin
                pair = average_bytes(left_pixel, px);
                slot = (col / 2) % PAIR_DEPTH;
                if (row % 2 == 0) begin
                    pair_row[slot] = pair;
                end else begin
                    res.scaled  = average_bytes(pair_row[slot], pair);
                    res.last    = (col == w - 1) && (row == h - 1);
                    res.odd_err = 1'b0;
                    expected_results.push_back(res);
                end
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        end
    endtask

    task automatic compare_result();
        t_scaled_result exp;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: scaled_pixel %h", i_scaled_pixel);
            fails++;
        end else begin
            exp = expected_results.pop_front();
            checked++;
            if (i_scaled_pixel !== exp.scaled) begin
                $error("scaled_pixel: expected %h, actual %h", exp.scaled, i_scaled_pixel);
                fails++;
            end
            if (i_last_of_image !== exp.last) begin
                $error("last_of_image: expected %b, actual %b", exp.last, i_last_of_image);
                fails++;
            end
            if (i_odd_size_error !== exp.odd_err) begin
                $error("odd_size_error: expected %b, actual %b", exp.odd_err, i_odd_size_error);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_width   = LINE_WIDTH_RST;
            image_height = IMAGE_HEIGHT_RST;
            left_pixel   = '0;
            col          = 0;
            row          = 0;
            expected_results.delete();
        end else begin
            // pop first: a result never comes from a pixel of the same edge
            if (i_res_valid && i_res_ready) compare_result();
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LINE_WIDTH) line_width = i_cfg_data;
                else if (i_cfg_index == CFG_IMAGE_HEIGHT) image_height = i_cfg_data;
                col = 0;
                row = 0;
            end
            if (i_pix_valid && i_pix_ready) predict_pixel(i_pixel);
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
    end

endmodule

// File: tb/tb_argb_half_scale_box_filter.sv
`timescale 1ns / 1ps

module tb_argb_half_scale_box_filter;
    import ahsbf_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;     // settle time once no results are pending
    localparam int RANDOM_PIXELS = 1700;

    // Indexes with no register behind them; a write still restarts the image.
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idling;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [PIXEL_W-1:0] i_pixel     = '0;
    logic               i_ready     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]   i_cfg_index = CFG_LINE_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data  = '0;

    logic               o_ready;
    logic               o_valid;
    logic [PIXEL_W-1:0] o_scaled_pixel;
    logic               o_last_of_image;
    logic               o_odd_size_error;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_sent    = 0;
    int reg_writes     = 0;
    int cycle_count    = 0;

    argb_half_scale_box_filter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel          (i_pixel),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_scaled_pixel   (o_scaled_pixel),
        .o_last_of_image  (o_last_of_image),
        .o_odd_size_error (o_odd_size_error),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    ahsbf_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pix_valid      (i_valid),
        .i_pix_ready      (o_ready),
        .i_pixel          (i_pixel),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_scaled_pixel   (o_scaled_pixel),
        .i_last_of_image  (o_last_of_image),
        .i_odd_size_error (o_odd_size_error),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: stall at the rate of the current phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: abort a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 45;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 45;
            end
            default: begin
                send_idle_pct  = 25;
                recv_stall_pct = 25;
            end
        endcase
    endtask

    // Mostly full-range random, sometimes bytes near the edges of the range.
    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] px;
        px = $urandom;
        if ($urandom_range(3) == 0) begin
            for (int k = 0; k < PIXEL_W / 8; k++) begin
                case ($urandom_range(3))
                    0: px[8*k +: 8] = 8'h00;
                    1: px[8*k +: 8] = 8'hff;
                    2: px[8*k +: 8] = 8'h01;
                    default: px[8*k +: 8] = 8'hfe;
                endcase
            end
        end
        return px;
    endfunction

    // Send one pixel transaction; hold valid and payload until accepted.
    task automatic push_pixel(input logic [PIXEL_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) push_pixel(random_pixel());
    endtask

    // Drop valid, drain every expected result, then let the pipeline settle
    // since even-row pixels leave nothing behind to wait for.
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_writes++;
    endtask

    task automatic configure(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
        write_reg(CFG_LINE_WIDTH, width);
        write_reg(CFG_IMAGE_HEIGHT, height);
    endtask

    initial begin
        int random_start;
        int phase;
        int w;
        int h;
        int ew;
        int eh;

        // Hold reset, then release it.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        random_start = pixels_sent;

        // Check the reset size: two full rows of a 640-wide image.
        set_idling(IDLE_NONE);
        send_random(2 * 640);

        // Smallest image, extreme pixel values and byte truncation.
        configure(13'd2, 13'd2);
        push_pixel(32'h0000_0000); push_pixel(32'h0000_0000);
        push_pixel(32'h0000_0000); push_pixel(32'h0000_0000);
        push_pixel(32'hffff_ffff); push_pixel(32'h0000_0000);
        push_pixel(32'h0000_0000); push_pixel(32'hffff_ffff);
        push_pixel(32'h0101_0101); push_pixel(32'h0000_0000);
        push_pixel(32'hfeff_0180); push_pixel(32'hffff_ffff);

        // Odd width, at the top of the register range.
        configure(13'd8191, 13'd2);
        push_pixel(32'hdead_beef); push_pixel(32'hffff_ffff);

        // Odd height.
        configure(13'd2, 13'd5);
        push_pixel(32'h1234_5678);

        // Zero counts as two.
        configure(13'd0, 13'd0);
        send_random(4);

        // Restart mid-row through an index with no register.
        configure(13'd4, 13'd2);
        send_random(3);
        write_reg(CFG_SPARE_LO, 13'h1abc);
        send_random(8);

        // Clamped extremes: start a widest row, then a tallest image.
        set_idling(IDLE_BOTH);
        configure(13'd8190, 13'd2);
        send_random(128);
        set_idling(IDLE_RECEIVER);
        configure(13'd2, 13'd8190);
        send_random(128);

        phase = 0;

        // Random phases: mostly whole images of small sizes, plus odd sizes,
        // images cut short and restarts through the spare indexes.
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            set_idling(t_idling'(phase % 4));
            w  = 2 * $urandom_range(1, 8);
            h  = 2 * $urandom_range(1, 4);
            if ($urandom_range(7) == 0) w = 0;
            if ($urandom_range(7) == 0) h = 0;
            ew = (w < 2) ? 2 : w;
            eh = (h < 2) ? 2 : h;
            case ($urandom_range(9))
                7: begin
                    // force at least one odd size anywhere in the register range
                    w = $urandom_range(0, 8191);
                    h = $urandom_range(0, 8191);
                    if (w % 2 == 0 && h % 2 == 0) begin
                        if ($urandom_range(1)) w = w | 1;
                        else h = h | 1;
                    end
                    configure(CFG_W'(w), CFG_W'(h));
                    send_random($urandom_range(1, 6));
                end
                8, 9: begin
                    configure(CFG_W'(w), CFG_W'(h));
                    send_random($urandom_range(1, ew * eh - 1));
                    if ($urandom_range(1)) begin
                        write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                  CFG_W'($urandom));
                        send_random(ew * eh);
                    end
                end
                default: begin
                    configure(CFG_W'(w), CFG_W'(h));
                    send_random(ew * eh * $urandom_range(1, 3));
                end
            endcase
            phase++;
        end

        // Drain and let the pipeline go quiet.
        wait_idle();

        $display("Checked %0d results from %0d pixels over %0d register writes.",
                 checked, pixels_sent, reg_writes);
        $display("Sizes from 2x2 up to clamped widths and heights, odd sizes and restarts.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: argb_half_scale_box_filter.f
rtl/ahsbf_pkg.sv
rtl/ahsbf_ram.sv
rtl/argb_half_scale_box_filter.sv
tb/ahsbf_result_checker.sv
tb/tb_argb_half_scale_box_filter.sv
